[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/cena_pkg.sv]
package cena_pkg;

   localparam int INDEX_W = 8;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 9;
   localparam int CSR_W   = 9;

   localparam logic [CSR_W-1:0] USED_RESET = 9'd256;

   typedef enum logic [1:0] {
      FUNC_LOAD_FIRST  = 2'd0,
      FUNC_LOAD_SECOND = 2'd1,
      FUNC_QUERY       = 2'd2
   } func_type;

endpackage

[hw/rtl/count_entries_not_above.sv]
// Channel | Dir | Handshake           | Payload
// req     | in  | req_tvalid/tready   | tdata {entry_value, entry_index}, tuser func,
//         |     |                     | tlast last_query
// rsp     | out | rsp_tvalid/tready   | tdata count_not_above, tuser bad_index,
//         |     |                     | tlast last_result
// csr     | in  | csr_valid/ready     | csr_data entries_in_use
//
// Loads are written in S_IDLE. A query runs S_KEY for the first-table read,
// S_SCAN for one second-table read per entry in use (used = entries in use),
// then S_OUT to hand off to the output register; the scan over the second-table
// RAM port is the longest step. A bad-index query goes from S_IDLE to S_OUT.
// Reset is synchronous, active high; it restores entries_in_use to 256 and
// leaves the table RAMs as they are. A new item is taken while a result still
// waits in the output register; a query then waits in S_OUT until rsp drains.
module count_entries_not_above
   import cena_pkg::*;
#(
   parameter int MAX_ENTRIES = 256
) (
   input  logic             clock,
   input  logic             reset,
   // request items
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [39:0]      req_tdata,   // [7:0] entry_index, [39:8] entry_value
   input  logic [1:0]       req_tuser,   // [1:0] func
   input  logic             req_tlast,   // last_query
   // result items
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [15:0]      rsp_tdata,   // [8:0] count_not_above, [15:9] zero
   output logic             rsp_tuser,   // [0] bad_index
   output logic             rsp_tlast,   // last_result
   // config register
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_data     // entries_in_use
);

   `include "assert_macros.svh"

   // Only 256 positions are reachable through entry_index.
   localparam int TBL_DEPTH = (MAX_ENTRIES < 256) ? MAX_ENTRIES : 256;
   localparam int ADDR_W    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

   typedef enum logic [1:0] {S_IDLE, S_KEY, S_SCAN, S_OUT} state_type;

   state_type                   state_ff, state_in;
   logic [CSR_W-1:0]            csr_ff, csr_in;
   logic [CSR_W-1:0]            used_ff, used_in;
   logic [COUNT_W-1:0]          j_ff, j_in;        // entry whose data is on rd_second
   logic [COUNT_W-1:0]          cnt_ff, cnt_in;
   logic signed [VALUE_W-1:0]   key_ff, key_in;
   logic                        bad_ff, bad_in;
   logic                        last_ff, last_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]          rsp_count_ff, rsp_count_in;
   logic                        rsp_bad_ff, rsp_bad_in;
   logic                        rsp_last_ff, rsp_last_in;

   func_type                    req_func;
   logic [INDEX_W-1:0]          req_index;
   logic [VALUE_W-1:0]          req_value;
   logic [ADDR_W-1:0]           req_addr;
   logic                        req_accept;
   logic                        in_table;
   logic [CSR_W-1:0]            used_now;
   logic [COUNT_W-1:0]          j_next;
   logic [ADDR_W-1:0]           scan_addr;
   logic                        wr_first, wr_second;
   logic signed [VALUE_W-1:0]   rd_first, rd_second;
   logic                        rsp_free;

   assign req_func   = func_type'(req_tuser);
   assign req_index  = req_tdata[INDEX_W-1:0];
   assign req_value  = req_tdata[INDEX_W+VALUE_W-1:INDEX_W];
   assign req_addr   = ADDR_W'(req_index);
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // writes beyond the table are dropped
   assign in_table  = ({1'b0, req_index} < CSR_W'(TBL_DEPTH));
   assign used_now  = (csr_ff > CSR_W'(TBL_DEPTH)) ? CSR_W'(TBL_DEPTH) : csr_ff;

   assign wr_first  = req_accept && (req_func == FUNC_LOAD_FIRST) && in_table;
   assign wr_second = req_accept && (req_func == FUNC_LOAD_SECOND) && in_table;

   // Loads only land in S_IDLE, where a query item issues its own first-table read,
   // and second-table reads run outside it, so no read that is used meets a write.
   assign j_next    = j_ff + COUNT_W'(1);
   assign scan_addr = (state_ff == S_SCAN) ? j_next[ADDR_W-1:0] : '0;

   cena_ram #(.WIDTH(VALUE_W), .DEPTH(TBL_DEPTH)) u_first_ram (
      .clock   (clock),
      .wr_en   (wr_first),
      .wr_addr (req_addr),
      .wr_data (req_value),
      .rd_addr (req_addr),
      .rd_data (rd_first)
   );

   cena_ram #(.WIDTH(VALUE_W), .DEPTH(TBL_DEPTH)) u_second_ram (
      .clock   (clock),
      .wr_en   (wr_second),
      .wr_addr (req_addr),
      .wr_data (req_value),
      .rd_addr (scan_addr),
      .rd_data (rd_second)
   );

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      csr_in       = csr_ff;
      used_in      = used_ff;
      j_in         = j_ff;
      cnt_in       = cnt_ff;
      key_in       = key_ff;
      bad_in       = bad_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_valid) begin
         csr_in = csr_data;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               case (req_func)
                  FUNC_QUERY: begin
                     last_in = req_tlast;
                     used_in = used_now;
                     cnt_in  = '0;
                     if ({1'b0, req_index} >= used_now) begin
                        bad_in   = 1'b1;
                        state_in = S_OUT;
                     end else begin
                        bad_in   = 1'b0;
                        state_in = S_KEY;
                     end
                  end
                  default: ;  // loads go straight to the RAMs; code three is dropped
               endcase
            end
         end
         S_KEY: begin
            // first-table entry arrives; second-table entry 0 is in flight
            key_in   = rd_first;
            j_in     = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (rd_second <= key_ff) begin
               cnt_in = cnt_ff + COUNT_W'(1);
            end
            if (j_ff == used_ff - CSR_W'(1)) begin
               state_in = S_OUT;
            end else begin
               j_in = j_next;
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = cnt_ff;
               rsp_bad_in   = bad_ff;
               rsp_last_in  = last_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         csr_ff       <= USED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_ff       <= csr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      used_ff      <= used_in;
      j_ff         <= j_in;
      cnt_ff       <= cnt_in;
      key_ff       <= key_in;
      bad_ff       <= bad_in;
      last_ff      <= last_in;
      rsp_count_ff <= rsp_count_in;
      rsp_bad_ff   <= rsp_bad_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16-COUNT_W){1'b0}}, rsp_count_ff};
   assign rsp_tuser  = rsp_bad_ff;
   assign rsp_tlast  = rsp_last_ff;

   `ASSERT_IMPL(a_scan_in_range, clock, reset, state_ff == S_SCAN, j_ff < used_ff, "scan index past entries in use")
   `ASSERT_IMPL(a_count_bounded, clock, reset, state_ff == S_SCAN, cnt_ff <= j_ff, "count ahead of entries scanned")
   `ASSERT_IMPL(a_bad_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[COUNT_W-1:0] == '0, "bad index with nonzero count")
   `ASSERT_NEXT(a_query_start, clock, reset, req_accept && req_func == FUNC_QUERY, state_ff == S_KEY || state_ff == S_OUT, "query did not start")

endmodule

[hw/rtl/cena_ram.sv]
module cena_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import cena_pkg::*;

   localparam int TABLE_DEPTH  = 256;
   localparam int DRAIN_CYCLES = 300;      // outlasts the longest query, a full-table scan
   localparam int LIMIT_CYCLES = 5000000;
   localparam int HOLD_CYCLES  = 3000;     // long rsp stall to back up the block
   localparam int PHASE_ITEMS  = 178;
   localparam int PHASES       = 8;
   localparam logic [1:0]         FUNC_UNUSED = 2'd3;
   localparam logic [VALUE_W-1:0] VALUE_MIN   = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] VALUE_MAX   = 32'h7FFF_FFFF;

   typedef struct {
      logic [COUNT_W-1:0] count;
      logic               bad;
      logic               last;
   } rank_result_type;

   // Shadow tables plus the queue of ranks still owed by the block.
   class rank_checker;
      logic signed [VALUE_W-1:0] first_table [TABLE_DEPTH];
      logic signed [VALUE_W-1:0] second_table [TABLE_DEPTH];
      logic [CSR_W-1:0]          entries_in_use;
      rank_result_type           pending_ranks [$];
      int                        errors;

      function new();
         entries_in_use = USED_RESET;
         errors = 0;
      endfunction

      function int used();
         return (entries_in_use > TABLE_DEPTH) ? TABLE_DEPTH : int'(entries_in_use);
      endfunction

      function void note_config(logic [CSR_W-1:0] value);
         entries_in_use = value;
      endfunction

      // entries of the second table in use that do not exceed first_table[idx]
      function logic [COUNT_W-1:0] upper_bound_rank(logic [INDEX_W-1:0] idx);
         logic [COUNT_W-1:0] count;
         count = '0;
         for (int i = 0; i < used(); i++) begin
            if (second_table[i] <= first_table[idx]) count++;
         end
         return count;
      endfunction

      function void note_request(logic [1:0] func, logic [INDEX_W-1:0] idx,
                                 logic [VALUE_W-1:0] value, logic last);
         rank_result_type res;
         case (func)
            FUNC_LOAD_FIRST: begin
               first_table[idx] = value;
            end
            FUNC_LOAD_SECOND: begin
               second_table[idx] = value;
            end
            FUNC_QUERY: begin
               res.bad   = (idx >= used());
               res.count = res.bad ? '0 : upper_bound_rank(idx);
               res.last  = last;
               pending_ranks = {pending_ranks, res};
            end
            default: begin
               // unused code: dropped by the block
            end
         endcase
      endfunction

      function void check_result(logic [15:0] data, logic bad, logic last);
         rank_result_type exp;
         if (pending_ranks.size() == 0) begin
            $display("%0t: unexpected result count %0d bad %0d last %0d",
                     $time, data[COUNT_W-1:0], bad, last);
            errors++;
            return;
         end
         exp = pending_ranks.pop_front();
         if (data[COUNT_W-1:0] !== exp.count) begin
            $display("%0t: count expected %0d actual %0d", $time, exp.count,
                     data[COUNT_W-1:0]);
            errors++;
         end
         if (data[15:COUNT_W] !== '0) begin
            $display("%0t: tdata pad expected 0 actual %h", $time, data[15:COUNT_W]);
            errors++;
         end
         if (bad !== exp.bad) begin
            $display("%0t: bad_index expected %0d actual %0d", $time, exp.bad, bad);
            errors++;
         end
         if (last !== exp.last) begin
            $display("%0t: last expected %0d actual %0d", $time, exp.last, last);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [39:0]        req_tdata  = '0;   // [7:0] entry_index, [39:8] entry_value
   logic [1:0]         req_tuser  = '0;   // [1:0] func
   logic               req_tlast  = 1'b0; // last_query
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [15:0]        rsp_tdata;         // [8:0] count_not_above, [15:9] zero
   logic               rsp_tuser;         // [0] bad_index
   logic               rsp_tlast;         // last_result
   logic               csr_valid  = 1'b0;
   logic               csr_ready;
   logic [CSR_W-1:0]   csr_data   = '0;   // entries_in_use

   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int recv_hold_left = 0;

   rank_checker ranks = new();

   count_entries_not_above #(
      .MAX_ENTRIES(TABLE_DEPTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   // rsp side: random back-pressure, or a long hold when asked for
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (recv_hold_left > 0) begin
            rsp_tready <= 1'b0;
            recv_hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         ranks.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // Values lean on the extremes and a narrow band so ranks tie often.
   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(9))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2:       return '0;
         3:       return '1;
         4, 5, 6: return $urandom_range(16) - 8;
         default: return $urandom();
      endcase
   endfunction

   // Called and left at a falling edge; valid stays up between back-to-back items.
   task automatic send_req(input logic [1:0] func, input logic [INDEX_W-1:0] idx,
                           input logic [VALUE_W-1:0] value, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {value, idx};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      ranks.note_request(func, idx, value, last);
      @(negedge clock);
   endtask

   task automatic write_entries_in_use(input logic [CSR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      ranks.note_config(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Loads and unused codes give nothing back, so pad with the worst query time.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (ranks.pending_ranks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // both ends of the in-use range, the first index past it, a dropped code and index 255
   task automatic probe_edges();
      int n;
      n = ranks.used();
      send_req(FUNC_QUERY, '0, $urandom(), 1'b0);
      if (n > 0) send_req(FUNC_QUERY, INDEX_W'(n - 1), $urandom(), 1'b0);
      if (n < TABLE_DEPTH) send_req(FUNC_QUERY, INDEX_W'(n), $urandom(), 1'b0);
      send_req(FUNC_UNUSED, '1, VALUE_MAX, 1'b1);
      send_req(FUNC_QUERY, '1, $urandom(), 1'b1);
   endtask

   // Mostly in-range queries against live tables, with loads mixed in,
   // some out-of-range queries and an occasional dropped code.
   task automatic send_random();
      int                 roll;
      int                 n;
      logic [INDEX_W-1:0] idx;
      roll = $urandom_range(99);
      n = ranks.used();
      if (roll < 60) begin
         if (n > 0 && (roll < 50 || n == TABLE_DEPTH))
            idx = INDEX_W'($urandom_range(n - 1));
         else
            idx = INDEX_W'($urandom_range(TABLE_DEPTH - 1, n));
         send_req(FUNC_QUERY, idx, $urandom(), $urandom_range(3) == 0);
      end else if (roll < 77) begin
         send_req(FUNC_LOAD_FIRST, INDEX_W'($urandom_range(255)), pick_value(),
                  1'($urandom_range(1)));
      end else if (roll < 95) begin
         send_req(FUNC_LOAD_SECOND, INDEX_W'($urandom_range(255)), pick_value(),
                  1'($urandom_range(1)));
      end else begin
         send_req(FUNC_UNUSED, INDEX_W'($urandom_range(255)), $urandom(),
                  1'($urandom_range(1)));
      end
   endtask

   initial begin
      logic [CSR_W-1:0] phase_used [PHASES];
      phase_used = '{USED_RESET, 9'd1, 9'd0, 9'd511, 9'd255, 9'd2, 9'd256, 9'd0};
      phase_used[PHASES-1] = CSR_W'($urandom_range(TABLE_DEPTH, 3));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Every entry gets written before any query reads it: the RAMs come
      // out of reset holding garbage.
      send_idle_pct = 16;
      recv_idle_pct = 59;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         send_req(FUNC_LOAD_FIRST, INDEX_W'(i), pick_value(), 1'b0);
         send_req(FUNC_LOAD_SECOND, INDEX_W'(i), pick_value(), 1'b0);
      end

      // min and max keys: only ties with the minimum count, or a full table
      send_req(FUNC_LOAD_FIRST, 8'd5, VALUE_MIN, 1'b0);
      send_req(FUNC_QUERY, 8'd5, $urandom(), 1'b0);
      send_req(FUNC_LOAD_FIRST, 8'd6, VALUE_MAX, 1'b0);
      send_req(FUNC_QUERY, 8'd6, $urandom(), 1'b1);

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            wait_drained();
            write_entries_in_use(phase_used[phase]);
         end
         if (phase < 3) begin
            send_idle_pct = 16;
            recv_idle_pct = 59;
         end else if (phase < 6) begin
            send_idle_pct = 59;
            recv_idle_pct = 16;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // full table, sender never idles: rsp stall backs the block up
         if (phase == 6) recv_hold_left = HOLD_CYCLES;
         // reset value, one entry, zero entries (all bad), saturating value
         if (phase < 4) probe_edges();
         for (int k = 0; k < PHASE_ITEMS; k++) send_random();
      end

      wait_drained();
      if (ranks.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
